>>> hdl/caef_pkg.sv
// Package for the ALU execute block: opcodes, modes, payload structs,
// controller/datapath command and status types. No dependencies.
package caef_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_CMP = 5'd5, OP_MOV = 5'd6, OP_XOR = 5'd7, OP_OR = 5'd8, OP_AND = 5'd9,
    OP_SHIFT = 5'd10, OP_BITOP = 5'd11, OP_SWAP = 5'd12, OP_EXT = 5'd13,
    OP_NOT = 5'd14, OP_NEG = 5'd15, OP_CHKX = 5'd16, OP_CHKV = 5'd17
  } op_e;

  localparam logic [2:0] SH_LSL = 3'd0, SH_ASR = 3'd1, SH_LSR = 3'd2, SH_ROL = 3'd3,
                         SH_ROR = 3'd4, SH_ROXL = 3'd5, SH_ROXR = 3'd6;
  localparam logic [2:0] BIT_CLR = 3'd0, BIT_SET = 3'd1, BIT_TST = 3'd2,
                         BIT_CPY = 3'd3, BIT_NOT = 3'd4;
  localparam logic [2:0] EXT_4 = 3'd0, EXT_8 = 3'd1, EXT_16 = 3'd2, EXT_20 = 3'd3;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 6;

  typedef struct packed {
    logic [4:0]  operation;
    logic [2:0]  mode;
    logic [31:0] dst_value;
    logic [31:0] src_value;
    logic        long_operand;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_x;
    logic        divide_by_zero;
  } out_item_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN, ST_OUT} state_e;

  typedef struct packed {
    logic load;      // capture input item
    logic div_step;  // one quotient bit
    logic finish;    // compute result and flags, load output
    logic out_done;  // output transfer done
  } cmd_t;

  typedef struct packed {
    logic is_div;    // loaded item needs the divider
    logic div_last;  // final quotient bit this cycle
  } stat_t;

endpackage

>>> hdl/caef_ctrl.sv
// Controller state machine for the ALU execute block.
// Depends on caef_pkg.
module caef_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  caef_pkg::stat_t stat_i,
  output caef_pkg::cmd_t  cmd_o
);
  import caef_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat_i.is_div) state_d = ST_FIN;
        else begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_last) state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.out_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.finish, cmd_o.out_done}))
    else $error("overlapping commands");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish not followed by output");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o) else $error("accepted while busy");
endmodule

>>> hdl/caef_dp.sv
// Datapath for the ALU execute block: operand registers, restoring divider,
// result and flag logic, status flags and output register. Depends on caef_pkg.
module caef_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  caef_pkg::cmd_t      cmd_i,
  output caef_pkg::stat_t     stat_o,
  input  caef_pkg::in_item_t  in_i,
  output caef_pkg::out_item_t out_o
);
  import caef_pkg::*;

  in_item_t    it_q;
  logic [3:0]  flags_q, flags_d;        // {X,V,Z,N}
  logic [31:0] quo_q, rem_q, mb_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0] mul_q;
  out_item_t   out_q;
  out_item_t   fin_item;

  logic [31:0] a, b, ma, mb;
  logic [4:0]  sh;
  logic [31:0] mask;
  assign a  = it_q.dst_value;
  assign b  = it_q.src_value;
  assign sh = b[4:0];
  assign mask = 32'd1 << sh;
  assign ma = in_i.dst_value[31] ? (32'd0 - in_i.dst_value) : in_i.dst_value;
  assign mb = in_i.src_value[31] ? (32'd0 - in_i.src_value) : in_i.src_value;

  logic is_div_ld;
  assign is_div_ld = (in_i.operation == OP_DIV || in_i.operation == OP_MOD)
                     && in_i.src_value != 32'd0;
  assign stat_o.is_div   = (it_q.operation == OP_DIV || it_q.operation == OP_MOD)
                           && b != 32'd0;
  assign stat_o.div_last = (cnt_q == CntW'(DataW - 1));

  // restoring step: shift in next dividend bit from quo_q
  logic [32:0] trial;
  assign trial = {rem_q, quo_q[31]} - {1'b0, mb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q  <= in_i;
      quo_q <= ma;
      rem_q <= '0;
      mb_q  <= mb;
      cnt_q <= '0;
      mul_q <= in_i.dst_value * in_i.src_value;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.finish) out_q <= fin_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flags_q <= '0;
    else if (cmd_i.finish) flags_q <= flags_d;
  end

  // rotates; roxl/roxr as 33-bit rotate through X
  logic [63:0] rl2, rr2;
  logic [32:0] xr;
  logic [65:0] xl2, xr2;
  assign rl2 = {a, a} << sh;
  assign rr2 = {a, a} >> sh;
  assign xr  = {flags_q[3], a};
  assign xl2 = {xr, xr} << sh;
  assign xr2 = {xr, xr} >> sh;

  logic [31:0] r, sw, q, m;
  logic        wr, dz, nz;
  logic [3:0]  f;

  always_comb begin
    f  = flags_q;
    r  = a;
    wr = 1'b1;
    dz = 1'b0;
    nz = 1'b0;
    q  = (a[31] ^ b[31]) ? (32'd0 - quo_q) : quo_q;
    m  = a[31] ? (32'd0 - rem_q) : rem_q;
    sw = a;
    case (it_q.operation)
      OP_ADD: begin
        r = a + b; nz = 1'b1; f[2] = (a[31] ^ r[31]) & (b[31] ^ r[31]);
      end
      OP_SUB: begin
        r = a - b; nz = 1'b1; f[2] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
      end
      OP_MUL: begin r = mul_q; nz = 1'b1; end
      OP_DIV, OP_MOD: begin
        if (b == 32'd0) begin wr = 1'b0; dz = 1'b1; end
        else begin
          r = (it_q.operation == OP_DIV) ? q : m; nz = 1'b1;
        end
      end
      OP_CMP: begin r = a - b; nz = 1'b1; wr = 1'b0; end
      OP_MOV: r = b;
      OP_XOR, OP_OR, OP_AND: begin
        r = (it_q.operation == OP_XOR) ? (a ^ b) :
            (it_q.operation == OP_OR) ? (a | b) : (a & b);
        nz = it_q.long_operand;
      end
      OP_SHIFT: begin
        nz = 1'b1;
        case (it_q.mode)
          SH_LSL: begin f[3] = a[31]; r = a << sh; end
          SH_ASR: begin f[3] = a[0]; r = 32'($signed(a) >>> sh); end
          SH_LSR: begin f[3] = a[0]; r = a >> sh; end
          SH_ROL: r = rl2[63:32];
          SH_ROR: r = rr2[31:0];
          SH_ROXL: begin r = xl2[64:33]; f[3] = xl2[65]; end
          SH_ROXR: begin r = xr2[31:0]; f[3] = xr2[32]; end
          default: r = a;
        endcase
      end
      OP_BITOP: begin
        case (it_q.mode)
          BIT_CLR: begin r = a & ~mask; nz = 1'b1; end
          BIT_SET: begin r = a | mask; nz = 1'b1; end
          BIT_TST: begin f[1] = (a & mask) == 32'd0; f[0] = 1'b0; wr = 1'b0; end
          BIT_CPY: begin r = flags_q[1] ? (a | mask) : (a & ~mask); nz = 1'b1; end
          BIT_NOT: begin r = a ^ mask; nz = 1'b1; end
          default: r = a;
        endcase
      end
      OP_SWAP: begin
        if (it_q.mode[0]) sw = {sw[15:0], sw[31:16]};
        if (it_q.mode[1]) sw = {sw[31:16], sw[7:0], sw[15:8]};
        if (it_q.mode[2]) sw = {sw[23:16], sw[31:24], sw[15:0]};
        r = sw; nz = 1'b1;
      end
      OP_EXT: begin
        nz = 1'b1;
        case (it_q.mode)
          EXT_4:  r = {{28{a[3]}}, a[3:0]};
          EXT_8:  r = {{24{a[7]}}, a[7:0]};
          EXT_16: r = {{16{a[15]}}, a[15:0]};
          EXT_20: r = {{12{a[19]}}, a[19:0]};
          default: r = a;
        endcase
      end
      OP_NOT: begin r = ~a; nz = 1'b1; end
      OP_NEG: begin r = 32'd0 - a; nz = 1'b1; end
      OP_CHKX: begin f[1] = flags_q[3]; wr = 1'b0; end
      OP_CHKV: begin f[1] = flags_q[2]; wr = 1'b0; end
      default: wr = 1'b0;
    endcase
    if (nz) begin f[0] = r[31]; f[1] = (r == 32'd0); end
    if (!wr) r = a;
    flags_d = f;
    fin_item = '{result: r, write_result: wr, flag_n: f[0], flag_z: f[1],
                 flag_v: f[2], flag_x: f[3], divide_by_zero: dz};
  end

  assign out_o = out_q;

  a_dz_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && dz |-> !wr) else $error("zero divisor wrote result");
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.finish) |-> $stable(flags_q)) else $error("flags moved");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q < CntW'(DataW)) else $error("divider overrun");
  a_ld_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && is_div_ld |=> stat_o.is_div) else $error("div not flagged");
endmodule

>>> hdl/cpu_alu_execute_with_flags.sv
// Top level of the ALU execute block with N, Z, V, X status flags.
// Depends on caef_pkg, caef_ctrl and caef_dp.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one in_item_t (operation,
//   mode, operands, long flag). A transfer happens on a clock edge with
//   valid high and stall low.
//   Output channel: out_valid_o / out_stall_i carry one out_item_t with the
//   new destination value, the write enable, the flags after the operation
//   and the divide-by-zero indication. Each input gives exactly one output.
//   The block works on one item at a time: the controller holds in_stall_o
//   high from acceptance until the output transfer.
//   From input transfer the controller steps through DIV and FIN to OUT,
//   where out_valid_o is high; div and mod with nonzero divisor run the
//   restoring divider in DIV, one quotient bit per cycle.
//   Multiply is registered at load and used at finish.
//   Reset clears the status flags and returns the controller to idle.
//   When the receiver stalls, the output item holds and no input is taken.
module cpu_alu_execute_with_flags (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  caef_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output caef_pkg::out_item_t out_data_o
);
  import caef_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  caef_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .stat_i(stat), .cmd_o(cmd)
  );

  caef_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .in_i(in_data_i), .out_o(out_data_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with output pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");
  a_accept_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o) else $error("early output");
endmodule

>>> test/cpu_alu_execute_with_flags_tb.sv
// Testbench for cpu_alu_execute_with_flags: directed and random ALU items
// checked against an in-bench flag-tracking predictor. Depends on caef_pkg.
`timescale 1ns / 1ps

module cpu_alu_execute_with_flags_tb;
  import caef_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  cpu_alu_execute_with_flags uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted status flags, mirroring the block's N Z V X
  logic      pf_n, pf_z, pf_v, pf_x;
  out_item_t alu_expected_q[$];
  int        mismatches;
  int        send_idle_pct, recv_idle_pct;
  bit        hold_recv;  // long receiver hold-off request
  int        hold_cycles;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  // Compute the result of one item and advance the predicted flags.
  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t o;
    logic [31:0] a, b, r, mask, ma, mb, q, m;
    logic [4:0]  sh;
    logic        n, z, v, x, wr, dz, ob;
    bit          tnz;
    a = it.dst_value; b = it.src_value; sh = b[4:0]; mask = 32'd1 << sh;
    n = pf_n; z = pf_z; v = pf_v; x = pf_x; r = a; wr = 1; dz = 0; tnz = 0;
    case (it.operation)
      OP_ADD: begin
        r = a + b; tnz = 1; v = (a[31] ^ r[31]) & (b[31] ^ r[31]);
      end
      OP_SUB: begin
        r = a - b; tnz = 1; v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
      end
      OP_MUL: begin r = a * b; tnz = 1; end
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          wr = 0; dz = 1;
        end else begin
          ma = abs32(a); mb = abs32(b); q = ma / mb; m = ma % mb;
          if (a[31] ^ b[31]) q = 32'd0 - q;
          if (a[31]) m = 32'd0 - m;
          r = (it.operation == OP_DIV) ? q : m; tnz = 1;
        end
      end
      OP_CMP: begin
        r = a - b; n = r[31]; z = (r == 0); wr = 0;
      end
      OP_MOV: r = b;
      OP_XOR, OP_OR, OP_AND: begin
        r = (it.operation == OP_XOR) ? a ^ b : (it.operation == OP_OR) ? a | b : a & b;
        tnz = it.long_operand;
      end
      OP_SHIFT: begin
        tnz = 1;
        case (it.mode)
          SH_LSL: begin x = a[31]; r = a << sh; end
          SH_ASR: begin x = a[0]; r = $signed(a) >>> sh; end
          SH_LSR: begin x = a[0]; r = a >> sh; end
          SH_ROL: r = (sh == 0) ? a : (a << sh) | (a >> (32 - sh));
          SH_ROR: r = (sh == 0) ? a : (a >> sh) | (a << (32 - sh));
          SH_ROXL: for (int i = 0; i < sh; i++) begin
            ob = r[31]; r = {r[30:0], x}; x = ob;
          end
          SH_ROXR: for (int i = 0; i < sh; i++) begin
            ob = r[0]; r = {x, r[31:1]}; x = ob;
          end
          default: ;
        endcase
      end
      OP_BITOP: begin
        case (it.mode)
          BIT_CLR: begin r = a & ~mask; tnz = 1; end
          BIT_SET: begin r = a | mask; tnz = 1; end
          BIT_TST: begin z = ((a & mask) == 0); n = 0; wr = 0; end
          BIT_CPY: begin r = z ? a | mask : a & ~mask; tnz = 1; end
          BIT_NOT: begin r = a ^ mask; tnz = 1; end
          default: ;
        endcase
      end
      OP_SWAP: begin
        if (it.mode[0]) r = {r[15:0], r[31:16]};
        if (it.mode[1]) r = {r[31:16], r[7:0], r[15:8]};
        if (it.mode[2]) r = {r[23:16], r[31:24], r[15:0]};
        tnz = 1;
      end
      OP_EXT: begin
        case (it.mode)
          EXT_4:  r = {{28{a[3]}}, a[3:0]};
          EXT_8:  r = {{24{a[7]}}, a[7:0]};
          EXT_16: r = {{16{a[15]}}, a[15:0]};
          EXT_20: r = {{12{a[19]}}, a[19:0]};
          default: ;
        endcase
        tnz = 1;
      end
      OP_NOT: begin r = ~a; tnz = 1; end
      OP_NEG: begin r = 32'd0 - a; tnz = 1; end
      OP_CHKX: begin z = x; wr = 0; end
      OP_CHKV: begin z = v; wr = 0; end
      default: wr = 0;
    endcase
    if (tnz) begin
      n = r[31]; z = (r == 0);
    end
    if (!wr) r = a;
    pf_n = n; pf_z = z; pf_v = v; pf_x = x;
    o.result = r; o.write_result = wr; o.flag_n = n; o.flag_z = z;
    o.flag_v = v; o.flag_x = x; o.divide_by_zero = dz;
    return o;
  endfunction

  // Offer one item; predict it at the transfer edge.
  task automatic send_alu_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    alu_expected_q.push_back(alu_predict(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(3);
      3: return 32'h7FFF_FFFF - $urandom_range(2);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation = ($urandom_range(49) == 0) ? 5'($urandom_range(31, 18))
                                             : 5'($urandom_range(17));
    it.mode = 3'($urandom);
    it.dst_value = rand_operand();
    it.src_value = ($urandom_range(9) == 0) ? 32'd0 : rand_operand();
    it.long_operand = 1'($urandom);
    return it;
  endfunction

  // Receiver: random stall, long hold-off on request; checks each transfer.
  always @(negedge clk_i) begin
    if (hold_recv && hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alu_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", out_data_o);
      end else begin
        e = alu_expected_q.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (alu_expected_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_item_t mk(op_e op, logic [2:0] md, logic [31:0] a,
                                  logic [31:0] b, logic lng);
    in_item_t it;
    it.operation = op; it.mode = md; it.dst_value = a; it.src_value = b;
    it.long_operand = lng;
    return it;
  endfunction

  // Field extremes, every op and the named corner cases.
  task automatic test_directed();
    send_alu_item(mk(OP_ADD, 0, 32'h7FFF_FFFF, 32'd1, 1));
    send_alu_item(mk(OP_SUB, 0, 32'h8000_0000, 32'd1, 0));
    send_alu_item(mk(OP_MUL, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_alu_item(mk(OP_DIV, 0, 32'h1234, 32'd0, 1));
    send_alu_item(mk(OP_DIV, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1));
    send_alu_item(mk(OP_MOD, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1));
    send_alu_item(mk(OP_MOD, 0, 32'hFFFF_FFF9, 32'd2, 1));
    send_alu_item(mk(OP_CMP, 0, 32'd5, 32'd5, 0));
    send_alu_item(mk(OP_MOV, 0, 32'd0, 32'hFFFF_FFFF, 0));
    send_alu_item(mk(OP_XOR, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send_alu_item(mk(OP_OR, 0, 32'h8000_0000, 32'd0, 0));
    send_alu_item(mk(OP_AND, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1));
    for (int m = 0; m < 8; m++)
      send_alu_item(mk(OP_SHIFT, 3'(m), 32'h8000_0001, 32'd0, 1));
    send_alu_item(mk(OP_SHIFT, SH_ROXR, 32'h8000_0001, 32'd31, 1));
    for (int m = 0; m < 8; m++)
      send_alu_item(mk(OP_BITOP, 3'(m), 32'h0000_0010, 32'hFFFF_FFE4, 1));
    send_alu_item(mk(OP_SWAP, 7, 32'h1234_5678, 32'd0, 0));
    for (int m = 0; m < 8; m++)
      send_alu_item(mk(OP_EXT, 3'(m), 32'h0008_8888, 32'd0, 0));
    send_alu_item(mk(OP_NOT, 0, 32'hFFFF_FFFF, 32'd0, 0));
    send_alu_item(mk(OP_NEG, 0, 32'h8000_0000, 32'd0, 0));
    send_alu_item(mk(OP_CHKX, 0, 32'd1, 32'd0, 0));
    send_alu_item(mk(OP_CHKV, 0, 32'd2, 32'd0, 0));
    send_alu_item(in_item_t'({5'd31, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_alu_item(rand_item());
  endtask

  // Receiver holds off while the sender keeps offering, then sender waits.
  task automatic test_backpressure();
    hold_cycles = 300;
    hold_recv = 1;
    test_random(20);
    hold_recv = 0;
    wait_drained();
    test_random(20);
  endtask

  initial begin
    mismatches = 0; hold_recv = 0; hold_cycles = 0;
    pf_n = 0; pf_z = 0; pf_v = 0; pf_x = 0;
    send_idle_pct = 9; recv_idle_pct = 77;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(550);
    send_idle_pct = 77; recv_idle_pct = 9;
    test_random(550);
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(600);
    wait_drained();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && alu_expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
